/* hdl/urs_pkg.sv */
// Types and codes shared by the uniform linear resampler.
`timescale 1ns / 1ps

package urs_pkg;

   typedef enum logic [2:0] {
      STATUS_INTERP = 3'd0,
      STATUS_FIRST  = 3'd1,
      STATUS_LAST   = 3'd2,
      STATUS_NEED   = 3'd3,
      STATUS_DONE   = 3'd4
   } status_type;

   typedef enum logic {
      ACTION_PUSH    = 1'b0,
      ACTION_REQUEST = 1'b1
   } action_type;

   typedef struct packed {
      action_type   action;
      logic [31:0]  knot_time;
      logic signed [31:0] knot_value;
      logic         knot_last;
   } req_type;

   typedef struct packed {
      logic signed [31:0] sample_value;
      logic [23:0]  sample_index;
      status_type   status;
   } rsp_type;

   localparam logic [0:0] REG_SAMPLE_PERIOD = 1'd0;
   localparam logic [0:0] REG_SAMPLE_COUNT  = 1'd1;

   localparam logic [23:0] SAMPLE_PERIOD_RESET = 24'd250;
   localparam logic [23:0] SAMPLE_COUNT_RESET  = 24'd1024;

endpackage

/* hdl/uniform_linear_resampler_core.sv */
// Uniform linear resampler: knot window, grid sequencer and shared add/sub datapath.
//
//   channel   direction  handshake           payload
//   req       in         req_valid/req_stall  req_data (urs_pkg::req_type)
//   rsp       out        rsp_valid/rsp_stall  rsp_data (urs_pkg::rsp_type)
//   csr       in/out     psel/penable/pready  paddr, pwdata, prdata
//
// A knot push is taken directly in the idle state. A request that holds a value or reports
// need-knot or finished passes through DECIDE and EMIT; an interpolated sample is
// computed by one 34-bit adder reused for 4 setup steps, 32 shift-add multiply steps,
// 33 restoring divide steps and a final add. Reset is synchronous and clears the
// knot window and grid position. A stalled result holds in the output register;
// the next request waits at its last step until that register is free.
`timescale 1ns / 1ps

module uniform_linear_resampler_core (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  urs_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output urs_pkg::rsp_type rsp_data,
   input  logic             psel,
   input  logic             penable,
   input  logic             pwrite,
   input  logic [2:0]       paddr,
   input  logic [31:0]      pwdata,
   output logic [31:0]      prdata,
   output logic             pready
);

   import urs_pkg::*;

   typedef enum logic [3:0] {
      IDLE, DECIDE, NUM, DEN, DIFF, ABSV, MUL, DIV, FIN, EMIT
   } state_type;

   state_type   state_ff, state_in;

   logic [23:0] period_ff, count_ff;
   logic [31:0] lt_ff, rt_ff;
   logic [31:0] lv_ff, rv_ff;
   logic [1:0]  held_ff;
   logic        end_ff;
   logic [23:0] index_ff;
   logic [47:0] time_ff;

   logic [31:0] num_ff, den_ff;
   logic [32:0] mag_ff;
   logic        neg_ff;
   logic [64:0] prod_ff;
   logic [5:0]  cnt_ff;
   logic [31:0] value_ff;
   status_type  status_ff;
   logic        adv_ff;

   logic        rsp_valid_ff;
   rsp_type     rsp_ff;

   logic [33:0] add_a, add_b, add_sum;
   logic        add_cin;
   logic        wr_en;
   logic        take_req;
   logic        rsp_free;
   logic        ge;
   logic        interp_run;

   assign pready    = 1'b1;
   assign wr_en     = psel && penable && pwrite;
   assign prdata    = (paddr[2] == REG_SAMPLE_COUNT) ? {8'd0, count_ff} : {8'd0, period_ff};
   assign req_stall = (state_ff != IDLE);
   assign take_req  = req_valid && (state_ff == IDLE);
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   assign interp_run = (index_ff < count_ff) && (held_ff == 2'd2) &&
                       (time_ff >= {16'd0, lt_ff}) && (time_ff <= {16'd0, rt_ff}) &&
                       (rt_ff != lt_ff);

   assign add_sum = add_a + add_b + {33'd0, add_cin};
   assign ge      = !add_sum[33];

   always_comb begin
      add_a   = '0;
      add_b   = '0;
      add_cin = 1'b0;
      unique case (state_ff)
         NUM: begin
            add_a   = {2'b0, time_ff[31:0]};
            add_b   = ~{2'b0, lt_ff};
            add_cin = 1'b1;
         end
         DEN: begin
            add_a   = {2'b0, rt_ff};
            add_b   = ~{2'b0, lt_ff};
            add_cin = 1'b1;
         end
         DIFF: begin
            add_a   = {{2{rv_ff[31]}}, rv_ff};
            add_b   = ~{{2{lv_ff[31]}}, lv_ff};
            add_cin = 1'b1;
         end
         ABSV: begin
            if (neg_ff) begin
               add_b   = ~{neg_ff, mag_ff};
               add_cin = 1'b1;
            end else begin
               add_a = {1'b0, mag_ff};
            end
         end
         MUL: begin
            add_a = {1'b0, prod_ff[64:32]};
            add_b = prod_ff[0] ? {1'b0, mag_ff} : 34'd0;
         end
         DIV: begin
            add_a   = {1'b0, prod_ff[64:32]};
            add_b   = ~{2'b0, den_ff};
            add_cin = 1'b1;
         end
         FIN: begin
            add_a   = {2'b0, lv_ff};
            add_b   = neg_ff ? ~{1'b0, prod_ff[32:0]} : {1'b0, prod_ff[32:0]};
            add_cin = neg_ff;
         end
         default: begin
            add_a = '0;
         end
      endcase
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         IDLE:   if (take_req && req_data.action == ACTION_REQUEST) state_in = DECIDE;
         DECIDE: state_in = interp_run ? NUM : EMIT;
         NUM:    state_in = DEN;
         DEN:    state_in = DIFF;
         DIFF:   state_in = ABSV;
         ABSV:   state_in = MUL;
         MUL:    if (cnt_ff == 6'd31) state_in = DIV;
         DIV:    if (cnt_ff == 6'd32) state_in = FIN;
         FIN:    state_in = EMIT;
         EMIT:   if (rsp_free) state_in = IDLE;
         default: state_in = IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= IDLE;
         period_ff    <= SAMPLE_PERIOD_RESET;
         count_ff     <= SAMPLE_COUNT_RESET;
         lt_ff        <= '0;
         rt_ff        <= '0;
         lv_ff        <= '0;
         rv_ff        <= '0;
         held_ff      <= '0;
         end_ff       <= 1'b0;
         index_ff     <= '0;
         time_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         adv_ff       <= 1'b0;
      end else begin
         state_ff <= state_in;

         if (wr_en) begin
            if (paddr[2] == REG_SAMPLE_COUNT) count_ff <= pwdata[23:0];
            else                              period_ff <= pwdata[23:0];
         end

         if (state_ff == EMIT && rsp_free) rsp_valid_ff <= 1'b1;
         else if (!rsp_stall)              rsp_valid_ff <= 1'b0;

         unique case (state_ff)
            IDLE: begin
               if (take_req && req_data.action == ACTION_PUSH && !end_ff) begin
                  priority if (held_ff == 2'd0) begin
                     lt_ff   <= req_data.knot_time;
                     lv_ff   <= req_data.knot_value;
                     held_ff <= 2'd1;
                  end else if (held_ff == 2'd1) begin
                     rt_ff   <= req_data.knot_time;
                     rv_ff   <= req_data.knot_value;
                     held_ff <= 2'd2;
                  end else begin
                     lt_ff <= rt_ff;
                     lv_ff <= rv_ff;
                     rt_ff <= req_data.knot_time;
                     rv_ff <= req_data.knot_value;
                  end
                  if (req_data.knot_last) end_ff <= 1'b1;
               end
            end
            DECIDE: begin
               priority if (index_ff >= count_ff) begin
                  status_ff <= STATUS_DONE;
                  value_ff  <= '0;
               end else if (held_ff == 2'd0) begin
                  status_ff <= STATUS_NEED;
                  value_ff  <= '0;
               end else if (time_ff < {16'd0, lt_ff}) begin
                  status_ff <= STATUS_FIRST;
                  value_ff  <= lv_ff;
               end else if (held_ff == 2'd1) begin
                  if (time_ff == {16'd0, lt_ff}) begin
                     status_ff <= STATUS_INTERP;
                     value_ff  <= lv_ff;
                  end else if (end_ff) begin
                     status_ff <= STATUS_LAST;
                     value_ff  <= lv_ff;
                  end else begin
                     status_ff <= STATUS_NEED;
                     value_ff  <= '0;
                  end
               end else if (time_ff <= {16'd0, rt_ff}) begin
                  status_ff <= STATUS_INTERP;
                  value_ff  <= lv_ff;
               end else if (end_ff) begin
                  status_ff <= STATUS_LAST;
                  value_ff  <= rv_ff;
               end else begin
                  status_ff <= STATUS_NEED;
                  value_ff  <= '0;
               end
            end
            FIN: begin
               value_ff <= add_sum[31:0];
            end
            EMIT: begin
               if (rsp_free) begin
                  rsp_ff.sample_value  <= value_ff;
                  rsp_ff.sample_index  <= index_ff;
                  rsp_ff.status        <= status_ff;
                  if (adv_ff) begin
                     index_ff <= index_ff + 24'd1;
                     time_ff  <= time_ff + {24'd0, period_ff};
                  end
               end
            end
            default: begin
               adv_ff <= adv_ff;
            end
         endcase

         if (state_ff == DECIDE) begin
            adv_ff <= (index_ff < count_ff) && (held_ff != 2'd0) &&
                      ((time_ff < {16'd0, lt_ff}) ||
                       ((held_ff == 2'd1) && ((time_ff == {16'd0, lt_ff}) || end_ff)) ||
                       ((held_ff == 2'd2) && ((time_ff <= {16'd0, rt_ff}) || end_ff)));
         end
      end
   end

   always_ff @(posedge clock) begin
      unique case (state_ff)
         NUM:  num_ff <= add_sum[31:0];
         DEN:  den_ff <= add_sum[31:0];
         DIFF: begin
            mag_ff <= add_sum[32:0];
            neg_ff <= add_sum[33];
         end
         ABSV: begin
            mag_ff  <= add_sum[32:0];
            prod_ff <= {33'd0, num_ff};
            cnt_ff  <= '0;
         end
         MUL: begin
            prod_ff <= {add_sum, prod_ff[31:1]};
            cnt_ff  <= (cnt_ff == 6'd31) ? 6'd0 : cnt_ff + 6'd1;
         end
         DIV: begin
            prod_ff <= {(ge ? add_sum[31:0] : prod_ff[63:32]), prod_ff[31:0], ge};
            cnt_ff  <= cnt_ff + 6'd1;
         end
         default: cnt_ff <= cnt_ff;
      endcase
   end

endmodule

/* sim/uniform_linear_resampler_core_tb.sv */
// Self-checking testbench for the uniform linear resampler core.
`timescale 1ns / 1ps

module uniform_linear_resampler_core_tb;
   import urs_pkg::*;

   localparam int QUIET_LIMIT = 3000;
   localparam int SETTLE_CYCLES = 80;

   logic clock;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   req_type req_data = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   rsp_type rsp_data;
   logic psel = 1'b0;
   logic penable = 1'b0;
   logic pwrite = 1'b0;
   logic [2:0] paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic pready;

   req_type pending_knots[$];
   rsp_type expected_samples[$];
   int errors = 0;
   int send_idle_pct = 0;
   int stall_pct = 0;
   int quiet_cycles = 0;

   // predicted state of the resampler
   logic [23:0] cfg_period = SAMPLE_PERIOD_RESET;
   logic [23:0] cfg_count = SAMPLE_COUNT_RESET;
   logic [31:0] left_t = '0;
   logic signed [31:0] left_v = '0;
   logic [31:0] right_t = '0;
   logic signed [31:0] right_v = '0;
   logic [1:0] knot_count = '0;
   logic final_seen = 1'b0;
   logic [23:0] grid_index = '0;
   logic [47:0] grid_time = '0;

   uniform_linear_resampler_core dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   always begin
      clock = 1'b1;
      #1;
      clock = 1'b0;
      #1;
   end

   function automatic logic signed [31:0] interpolate(input logic signed [31:0] lv,
                                                      input logic signed [31:0] rv,
                                                      input logic [31:0] num,
                                                      input logic [31:0] den);
      logic signed [32:0] dv;
      logic [63:0] mag;
      logic [63:0] q;
      dv = {rv[31], rv} - {lv[31], lv};
      mag = {31'b0, (dv[32] ? -dv : dv)};
      q = (mag * {32'b0, num}) / {32'b0, den};
      return dv[32] ? lv - q[31:0] : lv + q[31:0];
   endfunction

   task resample_step(input req_type item);
      logic [47:0] t;
      status_type st;
      logic signed [31:0] value;
      rsp_type want;
      t = grid_time;
      value = '0;
      if (item.action == ACTION_PUSH) begin
         if (!final_seen) begin
            if (knot_count == 2'd0) begin
               left_t = item.knot_time;
               left_v = item.knot_value;
               knot_count = 2'd1;
            end else if (knot_count == 2'd1) begin
               right_t = item.knot_time;
               right_v = item.knot_value;
               knot_count = 2'd2;
            end else begin
               left_t = right_t;
               left_v = right_v;
               right_t = item.knot_time;
               right_v = item.knot_value;
            end
            if (item.knot_last)
               final_seen = 1'b1;
         end
      end else begin
         if (grid_index >= cfg_count) begin
            st = STATUS_DONE;
         end else if (knot_count == 2'd0) begin
            st = STATUS_NEED;
         end else if (t < {16'b0, left_t}) begin
            st = STATUS_FIRST;
            value = left_v;
         end else if (knot_count == 2'd1) begin
            if (t == {16'b0, left_t}) begin
               st = STATUS_INTERP;
               value = left_v;
            end else if (final_seen) begin
               st = STATUS_LAST;
               value = left_v;
            end else begin
               st = STATUS_NEED;
            end
         end else if (t <= {16'b0, right_t}) begin
            st = STATUS_INTERP;
            if (right_t == left_t)
               value = left_v;
            else
               value = interpolate(left_v, right_v, t[31:0] - left_t, right_t - left_t);
         end else if (final_seen) begin
            st = STATUS_LAST;
            value = right_v;
         end else begin
            st = STATUS_NEED;
         end
         want.sample_value = value;
         want.sample_index = grid_index;
         want.status = st;
         expected_samples.push_back(want);
         if (st == STATUS_INTERP || st == STATUS_FIRST || st == STATUS_LAST) begin
            grid_index = grid_index + 24'd1;
            grid_time = grid_time + {24'b0, cfg_period};
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall)
            resample_step(req_data);
         if (!req_valid || !req_stall) begin
            if (pending_knots.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
               req_valid <= 1'b1;
               req_data <= pending_knots.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin : sample_monitor
      rsp_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_samples.size() == 0) begin
               $display("%0t: unexpected sample, expected none, got value %0d index %0d status %0d",
                        $time, rsp_data.sample_value, rsp_data.sample_index, rsp_data.status);
               errors++;
            end else begin
               want = expected_samples.pop_front();
               if (rsp_data.sample_value !== want.sample_value) begin
                  $display("%0t: sample_value mismatch, expected %0d, got %0d",
                           $time, want.sample_value, rsp_data.sample_value);
                  errors++;
               end
               if (rsp_data.sample_index !== want.sample_index) begin
                  $display("%0t: sample_index mismatch, expected %0d, got %0d",
                           $time, want.sample_index, rsp_data.sample_index);
                  errors++;
               end
               if (rsp_data.status !== want.status) begin
                  $display("%0t: status mismatch, expected %0d, got %0d",
                           $time, want.status, rsp_data.status);
                  errors++;
               end
            end
         end
         rsp_stall <= ($urandom_range(0, 99) < stall_pct);
      end
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || psel)
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   task push_knot(input logic [31:0] t, input logic [31:0] v, input logic last);
      req_type item;
      item.action = ACTION_PUSH;
      item.knot_time = t;
      item.knot_value = v;
      item.knot_last = last;
      pending_knots.push_back(item);
   endtask

   task request_sample();
      req_type item;
      item.action = ACTION_REQUEST;
      item.knot_time = $urandom;
      item.knot_value = $urandom;
      item.knot_last = 1'b0;
      pending_knots.push_back(item);
   endtask

   task drain();
      while (pending_knots.size() != 0 || req_valid || expected_samples.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task write_reg(input logic [0:0] index, input logic [23:0] value);
      @(posedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {index, 2'b00};
      pwdata <= {8'b0, value};
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      if (index == REG_SAMPLE_PERIOD)
         cfg_period = value;
      else
         cfg_count = value;
   endtask

   task set_idling(input int mode);
      case (mode % 4)
         0: begin send_idle_pct = 0; stall_pct = 0; end
         1: begin send_idle_pct = 53; stall_pct = 0; end
         2: begin send_idle_pct = 0; stall_pct = 53; end
         default: begin send_idle_pct = 9; stall_pct = 9; end
      endcase
   endtask

   // knots ahead of the grid with about one request per grid step, plus random items
   task run_phase(input int n_items);
      logic [31:0] kt;
      logic [31:0] delta;
      req_type item;
      int made;
      int nreq;
      kt = grid_time[31:0];
      made = 0;
      while (made < n_items) begin
         if ($urandom_range(0, 99) < 8) begin
            item.action = action_type'($urandom_range(0, 1));
            item.knot_time = $urandom;
            item.knot_value = $urandom;
            item.knot_last = 1'b0;
            pending_knots.push_back(item);
            made++;
         end else begin
            if ($urandom_range(0, 9) == 0)
               delta = 0;
            else
               delta = $urandom_range(1, 4 * cfg_period);
            kt = kt + delta;
            push_knot(kt, $urandom, 1'b0);
            nreq = int'(delta / {8'b0, cfg_period}) + $urandom_range(0, 2) - 1;
            if (nreq < 0)
               nreq = 0;
            repeat (nreq) request_sample();
            made += 1 + nreq;
         end
      end
   endtask

   initial begin : stimulus
      logic [31:0] base;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      request_sample();
      push_knot(32'd1000, 32'h0001_0000, 1'b0);
      repeat (6) request_sample();
      push_knot(32'd2000, 32'hFFFD_0000, 1'b0);
      repeat (5) request_sample();
      push_knot(32'd2250, 32'h0001_2345, 1'b0);
      push_knot(32'd2250, 32'h7FFF_FFFF, 1'b0);
      request_sample();
      push_knot(32'd3250, 32'h8000_0000, 1'b0);
      repeat (4) request_sample();
      push_knot(32'hFFFF_FFFF, 32'h0000_0000, 1'b0);
      request_sample();
      push_knot(32'd0, 32'hFFFF_FFFF, 1'b0);
      request_sample();
      drain();

      write_reg(REG_SAMPLE_COUNT, 24'd1);
      set_idling(3);
      repeat (3) request_sample();
      drain();
      write_reg(REG_SAMPLE_COUNT, 24'hFF_FFFF);

      for (int p = 0; p < 8; p++) begin
         drain();
         write_reg(REG_SAMPLE_PERIOD, (p == 0) ? 24'd1 : 24'($urandom_range(2, 700)));
         set_idling(p);
         run_phase(235);
      end

      drain();
      write_reg(REG_SAMPLE_PERIOD, 24'hFF_FFFF);
      set_idling(1);
      run_phase(20);

      // close the knot stream and run the grid past the final knot
      drain();
      write_reg(REG_SAMPLE_PERIOD, 24'd100);
      set_idling(3);
      base = grid_time[31:0];
      push_knot(base + 32'd50, $urandom, 1'b0);
      push_knot(base + 32'd250, $urandom, 1'b1);
      repeat (6) request_sample();
      push_knot(32'hFFFF_FFFF, $urandom, 1'b1);
      repeat (2) request_sample();
      drain();
      write_reg(REG_SAMPLE_COUNT, 24'd1);
      repeat (2) request_sample();
      drain();

      if (errors == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule
